[design/snf_pkg.sv]
package snf_pkg;

  typedef enum logic [1:0] {
    FUNC_KEY  = 2'd0,
    FUNC_NAME = 2'd1,
    FUNC_END  = 2'd2
  } func_e;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 16;
  localparam int unsigned LimitW = 16;
  localparam logic [LimitW-1:0] LimitReset = 16'd10000;

  typedef struct packed {
    logic             kw_load;
    logic             kw_first;
    logic             name_byte;
    logic             name_end;
    logic [ByteW-1:0] ch;
  } snf_cmd_t;

  typedef struct packed {
    logic found;
    logic key_empty;
  } snf_stat_t;

endpackage

[design/snf_matcher.sv]
module snf_matcher #(
  parameter int MAX_KEY_LEN = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  snf_pkg::snf_cmd_t   cmd_i,
  output snf_pkg::snf_stat_t  stat_o
);

  localparam int LenW = $clog2(MAX_KEY_LEN + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_KEY_LEN);

  // key_q[0] holds the newest keyword byte, window_q[0] the newest name byte
  logic [snf_pkg::ByteW-1:0] key_q    [MAX_KEY_LEN];
  logic [snf_pkg::ByteW-1:0] key_d    [MAX_KEY_LEN];
  logic [snf_pkg::ByteW-1:0] window_q [MAX_KEY_LEN];
  logic [snf_pkg::ByteW-1:0] window_d [MAX_KEY_LEN];
  logic [LenW-1:0]           len_q, len_d;
  logic [LenW-1:0]           fill_q, fill_d, fill_inc;
  logic                      ovf_q, ovf_d;
  logic                      found_q, found_d;
  logic                      all_eq;
  logic                      match_new;

  always_comb begin
    for (int k = 0; k < MAX_KEY_LEN; k++) begin
      if (k == 0) begin
        window_d[k] = cmd_i.ch;
      end else begin
        window_d[k] = window_q[k-1];
      end
    end
    fill_inc = (fill_q == LenMax) ? fill_q : fill_q + LenW'(1);
    all_eq = 1'b1;
    for (int k = 0; k < MAX_KEY_LEN; k++) begin
      if ((LenW'(k) < len_q) && (window_d[k] != key_q[k])) begin
        all_eq = 1'b0;
      end
    end
    match_new = all_eq && !ovf_q && (len_q != '0) && (fill_inc >= len_q);
  end

  always_comb begin
    for (int k = 0; k < MAX_KEY_LEN; k++) begin
      if (k == 0) begin
        key_d[k] = cmd_i.ch;
      end else begin
        key_d[k] = key_q[k-1];
      end
    end
  end

  always_comb begin
    len_d   = len_q;
    ovf_d   = ovf_q;
    fill_d  = fill_q;
    found_d = found_q;
    if (cmd_i.kw_load) begin
      if (cmd_i.kw_first) begin
        len_d   = LenW'(1);
        ovf_d   = 1'b0;
        fill_d  = '0;
        found_d = 1'b0;
      end else if (len_q < LenMax) begin
        len_d = len_q + LenW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end else if (cmd_i.name_byte) begin
      fill_d = fill_inc;
      if (match_new) begin
        found_d = 1'b1;
      end
    end else if (cmd_i.name_end) begin
      fill_d  = '0;
      found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      ovf_q   <= 1'b0;
      fill_q  <= '0;
      found_q <= 1'b0;
    end else begin
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      fill_q  <= fill_d;
      found_q <= found_d;
    end
  end

  // keyword shifts only while it still fits
  always_ff @(posedge clk_i) begin
    if (cmd_i.kw_load && (cmd_i.kw_first || (len_q < LenMax))) begin
      key_q <= key_d;
    end
    if (cmd_i.name_byte) begin
      window_q <= window_d;
    end
  end

  assign stat_o.found     = found_q;
  assign stat_o.key_empty = (len_q == '0) && !ovf_q;

endmodule

[design/substring_name_filter.sv]
// result path: an end marker is held in the input stage register, then its result is registered in the output register
// throughput: one item per cycle, set by the single compare stage
// the input stalls only while a result waits in the output register
// reset: keyword empty, counters zero, result limit 10000, no result pending
module substring_name_filter #(
  parameter int MAX_KEY_LEN = 32,
  parameter int MAX_NAMES   = 65536
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   func_i,
  input  logic [snf_pkg::ByteW-1:0]    ch_i,
  input  logic                         first_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [snf_pkg::LimitW-1:0]   cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [snf_pkg::IndexW-1:0]   name_index_o,
  output logic                         final_res_o
);

  localparam int NameW = $clog2(MAX_NAMES);
  localparam logic [NameW-1:0] NameLast = NameW'(MAX_NAMES - 1);

  logic                              s1_valid_q, s1_valid_d;
  logic [1:0]                        s1_func_q;
  logic [snf_pkg::ByteW-1:0]         s1_ch_q;
  logic                              s1_first_q;
  logic                              adv;
  logic                              emit;
  logic                              is_key, is_name, is_end;
  logic [NameW-1:0]                  name_cnt_q, name_cnt_d;
  logic [snf_pkg::LimitW-1:0]        hit_q, hit_d;
  logic [snf_pkg::LimitW:0]          hit_inc;
  logic [snf_pkg::LimitW-1:0]        limit_q, limit_d;
  logic                              out_valid_q, out_valid_d;
  logic [snf_pkg::IndexW-1:0]        out_index_q;
  logic                              out_final_q;
  logic [NameW+snf_pkg::IndexW-1:0]  name_ext;
  snf_pkg::snf_cmd_t                 cmd;
  snf_pkg::snf_stat_t                stat;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign s1_valid_d = in_ready_o ? in_valid_i : s1_valid_q;

  assign is_key  = s1_func_q == snf_pkg::FUNC_KEY;
  assign is_name = s1_func_q == snf_pkg::FUNC_NAME;
  assign is_end  = s1_func_q == snf_pkg::FUNC_END;

  assign cmd.kw_load   = adv && is_key;
  assign cmd.kw_first  = s1_first_q;
  assign cmd.name_byte = adv && is_name;
  assign cmd.name_end  = adv && is_end;
  assign cmd.ch        = s1_ch_q;

  snf_matcher #(
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_matcher (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .stat_o(stat)
  );

  assign hit_inc  = {1'b0, hit_q} + (snf_pkg::LimitW+1)'(1);
  assign emit     = adv && is_end && (stat.found || stat.key_empty) && (hit_q < limit_q);
  assign name_ext = {{snf_pkg::IndexW{1'b0}}, name_cnt_q};

  always_comb begin
    name_cnt_d = name_cnt_q;
    hit_d      = hit_q;
    if (adv && is_key && s1_first_q) begin
      name_cnt_d = '0;
      hit_d      = '0;
    end else if (adv && is_end) begin
      name_cnt_d = (name_cnt_q == NameLast) ? '0 : name_cnt_q + NameW'(1);
      if (emit) begin
        hit_d = hit_inc[snf_pkg::LimitW-1:0];
      end
    end
  end

  assign cfg_ready_o = 1'b1;
  assign limit_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : limit_q;

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      name_cnt_q  <= '0;
      hit_q       <= '0;
      limit_q     <= snf_pkg::LimitReset;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      name_cnt_q  <= name_cnt_d;
      hit_q       <= hit_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_func_q  <= func_i;
      s1_ch_q    <= ch_i;
      s1_first_q <= first_i;
    end
    if (emit) begin
      out_index_q <= name_ext[snf_pkg::IndexW-1:0];
      out_final_q <= hit_inc == {1'b0, limit_q};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign name_index_o = out_index_q;
  assign final_res_o  = out_final_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a pending result");

  a_new_key_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_key && s1_first_q |=> name_cnt_q == '0 && hit_q == '0)
    else $error("new keyword did not clear the counters");

  a_emit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q && hit_q != '0)
    else $error("result transfer without a counted hit");

  a_final_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && final_res_o |-> hit_q == limit_q)
    else $error("final result while hits are below the limit");

endmodule
